/* rtl/dpr_pkg.sv */
// Shared types and constants for the DAC persistence rate limiter.
`timescale 1ns / 1ps

package dpr_pkg;

  localparam int DAC_BITS = 12;
  localparam int TIME_W   = 32;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  // request types
  localparam logic REQ_LEVEL = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // write kinds (device commands 0x40 and 0x60)
  localparam logic WK_VOLATILE    = 1'b0;
  localparam logic WK_NONVOLATILE = 1'b1;

  localparam logic [7:0] CMD_VOLATILE    = 8'h40;
  localparam logic [7:0] CMD_NONVOLATILE = 8'h60;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_PERSIST_ENABLE  = 2'd0;
  localparam logic [1:0] REG_SAVE_THRESHOLD  = 2'd1;
  localparam logic [1:0] REG_MIN_INTERVAL_MS = 2'd2;
  localparam logic [1:0] REG_SAVE_DELAY_MS   = 2'd3;

  localparam logic [DAC_BITS-1:0] THRESHOLD_RST   = DAC_BITS'(41);
  localparam logic [TIME_W-1:0]   MIN_INTERVAL_RST = TIME_W'(60000);
  localparam logic [TIME_W-1:0]   SAVE_DELAY_RST  = TIME_W'(1000);

  typedef struct packed {
    logic                persist_enable;
    logic [DAC_BITS-1:0] save_threshold;
    logic [TIME_W-1:0]   min_interval_ms;
    logic [TIME_W-1:0]   save_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic                req_type;
    logic [DAC_BITS-1:0] level_code;
    logic [TIME_W-1:0]   now_ms;
  } item_t;

  typedef struct packed {
    logic                valid;
    logic                write_kind;
    logic [DAC_BITS-1:0] dac_code;
  } res_t;

endpackage

/* rtl/dpr_if.sv */
// Handshake channels for request items and result items.
`timescale 1ns / 1ps

interface dpr_req_if import dpr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [DAC_BITS-1:0] level_code;
  logic [TIME_W-1:0]   now_ms;

  modport source (output valid, req_type, level_code, now_ms, input ready);
  modport sink   (input valid, req_type, level_code, now_ms, output ready);
endinterface

interface dpr_res_if import dpr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                write_kind;
  logic [DAC_BITS-1:0] dac_code;

  modport source (output valid, write_kind, dac_code, input ready);
  modport sink   (input valid, write_kind, dac_code, output ready);
endinterface

/* rtl/dpr_cfg_regs.sv */
// APB configuration registers.
`timescale 1ns / 1ps

module dpr_cfg_regs import dpr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.persist_enable  <= 1'b0;
      cfg.save_threshold  <= THRESHOLD_RST;
      cfg.min_interval_ms <= MIN_INTERVAL_RST;
      cfg.save_delay_ms   <= SAVE_DELAY_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PERSIST_ENABLE:  cfg.persist_enable  <= pwdata[0];
        REG_SAVE_THRESHOLD:  cfg.save_threshold  <= pwdata[DAC_BITS-1:0];
        REG_MIN_INTERVAL_MS: cfg.min_interval_ms <= pwdata[TIME_W-1:0];
        REG_SAVE_DELAY_MS:   cfg.save_delay_ms   <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PERSIST_ENABLE:  prdata = DATA_W'(cfg.persist_enable);
      REG_SAVE_THRESHOLD:  prdata = DATA_W'(cfg.save_threshold);
      REG_MIN_INTERVAL_MS: prdata = DATA_W'(cfg.min_interval_ms);
      REG_SAVE_DELAY_MS:   prdata = DATA_W'(cfg.save_delay_ms);
      default:             prdata = '0;
    endcase
  end

endmodule

/* rtl/dpr_core.sv */
// Save scheduling state and the per-item decision logic.
`timescale 1ns / 1ps

module dpr_core import dpr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  adv,
  input  item_t item,
  output res_t  res
);

  logic [DAC_BITS-1:0] persisted_code;
  logic                persisted_known;
  logic [TIME_W-1:0]   last_save_time;
  logic                save_pending;
  logic [DAC_BITS-1:0] pending_code;
  logic [TIME_W-1:0]   save_due_time;

  logic [DAC_BITS-1:0] abs_diff;
  logic [TIME_W-1:0]   since_save;
  logic [TIME_W-1:0]   past_due;
  logic                is_level;
  logic                arm;
  logic                fire;

  always_comb begin
    is_level = (item.req_type == REQ_LEVEL);
    abs_diff = (item.level_code >= persisted_code) ? item.level_code - persisted_code
                                                   : persisted_code - item.level_code;
    since_save = item.now_ms - last_save_time;
    past_due   = item.now_ms - save_due_time;
    arm  = is_level && cfg.persist_enable
           && (!persisted_known || abs_diff >= cfg.save_threshold)
           && (since_save >= cfg.min_interval_ms);
    // wrap-safe: due once the difference is non-negative as a signed value
    fire = !is_level && save_pending && !past_due[TIME_W-1];

    res.valid      = is_level || fire;
    res.write_kind = is_level ? WK_VOLATILE : WK_NONVOLATILE;
    res.dac_code   = is_level ? item.level_code : pending_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      persisted_code  <= '0;
      persisted_known <= 1'b0;
      last_save_time  <= '0;
      save_pending    <= 1'b0;
      pending_code    <= '0;
      save_due_time   <= '0;
    end else if (adv) begin
      if (arm) begin
        save_pending  <= 1'b1;
        pending_code  <= item.level_code;
        save_due_time <= item.now_ms + cfg.save_delay_ms;
      end else if (fire) begin
        save_pending    <= 1'b0;
        persisted_code  <= pending_code;
        persisted_known <= 1'b1;
        last_save_time  <= item.now_ms;
      end
    end
  end

endmodule

/* rtl/dac_persist_rate_limiter.sv */
// Top level: input register, decision core, result register and APB registers.
`timescale 1ns / 1ps

// Takes one item per cycle, back to back, while the result side does not stall;
// items pass the input register, then the result register. The core reads and
// updates its save state in the same cycle, setting that rate. A new level always
// gives a volatile write result; a tick gives a non-volatile write result only
// when an armed save is due, otherwise nothing. A stalled result holds the
// pipeline; req.ready follows res.ready combinationally. The user must write
// configuration over APB only while no item is in flight; the block does not enforce this.
module dac_persist_rate_limiter import dpr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  dpr_req_if.sink           req,
  dpr_res_if.source         res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t  cfg;
  item_t s1_item;
  logic  s1_valid;
  logic  s1_adv;
  res_t  core_res;
  logic  out_free;

  dpr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign out_free  = !res.valid || res.ready;
  assign s1_adv    = s1_valid && out_free;
  assign req.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_item.req_type   <= req.req_type;
      s1_item.level_code <= req.level_code;
      s1_item.now_ms     <= req.now_ms;
    end
  end

  dpr_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .adv  (s1_adv),
    .item (s1_item),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_free) begin
      res.valid <= s1_adv && core_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && core_res.valid) begin
      res.write_kind <= core_res.write_kind;
      res.dac_code   <= core_res.dac_code;
    end
  end

  // a level item always yields a volatile write
  a_level_gives_volatile: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_item.req_type == REQ_LEVEL |=>
      res.valid && res.write_kind == WK_VOLATILE)
    else $error("level item gave no volatile write");

  // a due save shows up as a non-volatile write carrying the pending code
  a_fire_gives_nonvolatile: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_item.req_type == REQ_TICK && core_res.valid |=>
      res.valid && res.write_kind == WK_NONVOLATILE
      && res.dac_code == $past(core_res.dac_code))
    else $error("due save not delivered");

  // an item held in the input register stays put while the result side stalls
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_item))
    else $error("input register lost an item under stall");

endmodule
